// ===== hdl/tspf_pkg.sv =====
// ----------------------------------------------------------------------------
// Transport stream parser package
// Shared constants, register codes, state type and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package tspf_pkg;

    // Packet and capture geometry
    localparam int PACKET_BYTES  = 188;
    localparam int CAPTURE_BYTES = 14;

    localparam int POS_W  = $clog2(PACKET_BYTES);
    localparam int CNT_W  = $clog2(CAPTURE_BYTES + 1);
    localparam int CAP_AW = $clog2(CAPTURE_BYTES);
    localparam int IDX_W  = 4;
    localparam int OFF_W  = 10;

    localparam logic [7:0] SYNC_BYTE = 8'h47;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_PID    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ID      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE3_MATCH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE4_MATCH_A = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE4_MATCH_B = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_ALL    = 3'd5;

    localparam logic [12:0] RST_FILTER_PID = 13'd802;
    localparam logic [7:0]  RST_TABLE_ID   = 8'h3b;
    localparam logic [7:0]  RST_BYTE3      = 8'h00;
    localparam logic [7:0]  RST_BYTE4_A    = 8'h7d;
    localparam logic [7:0]  RST_BYTE4_B    = 8'h01;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DECIDE,
        ST_SUM,
        ST_DATA
    } state_t;

    typedef struct packed {
        logic             accept;
        logic             load_sum;
        logic             load_data;
        logic             last;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic pkt_end;
        logic matched;
        logic report_all;
        logic out_free;
    } status_t;

endpackage

// ===== hdl/tspf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Transport stream parser controller
// Sequences byte intake, the end-of-packet filter decision and the result beats.
// ----------------------------------------------------------------------------
module tspf_ctrl
    import tspf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t sts,
    output cmd_t    cmd
);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] emit_idx_reg, emit_idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_RUN;
            emit_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            emit_idx_reg <= emit_idx_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        emit_idx_next = emit_idx_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.idx       = emit_idx_reg;
        case (state_reg)
            ST_RUN:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && sts.pkt_end)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                emit_idx_next = '0;
                if (sts.report_all)
                begin
                    state_next = ST_SUM;
                end
                else if (sts.matched)
                begin
                    state_next = ST_DATA;
                end
                else
                begin
                    state_next = ST_RUN;
                end
            end
            ST_SUM:
            begin
                if (sts.out_free)
                begin
                    cmd.load_sum = 1'b1;
                    cmd.last     = !sts.matched;
                    state_next   = sts.matched ? ST_DATA : ST_RUN;
                end
            end
            ST_DATA:
            begin
                if (sts.out_free)
                begin
                    cmd.load_data = 1'b1;
                    cmd.last      = (emit_idx_reg == IDX_W'(CAPTURE_BYTES - 1));
                    emit_idx_next = emit_idx_reg + IDX_W'(1);
                    if (cmd.last)
                    begin
                        emit_idx_next = '0;
                        state_next    = ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

`ifndef SYNTH
    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.load_sum, cmd.load_data}))
        else $error("controller issued more than one action in a cycle");

    a_end_to_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && sts.pkt_end) |=> (state_reg == ST_DECIDE))
        else $error("packet end did not lead to the filter decision");

    a_last_beat_resumes: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_data && cmd.last) |=> (state_reg == ST_RUN && emit_idx_reg == '0))
        else $error("final section beat did not return to byte intake");
`endif

endmodule

// ===== hdl/tspf_dp.sv =====
// ----------------------------------------------------------------------------
// Transport stream parser datapath
// Header, adaptation and PCR decode, section capture, filter and output register.
// ----------------------------------------------------------------------------
module tspf_dp
    import tspf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            in_byte,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  cmd_t                  cmd,
    output status_t               sts,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic                  kind,
    output logic [31:0]           packet_index,
    output logic [12:0]           packet_pid,
    output logic [6:0]            header_bits,
    output logic [3:0]            continuity,
    output logic [7:0]            adapt_flags,
    output logic [32:0]           pcr_base,
    output logic [8:0]            pcr_extension,
    output logic [12:0]           section_length,
    output logic [7:0]            data_byte,
    output logic [3:0]            byte_index,
    output logic                  last
);

    // Configuration
    logic [12:0] filter_pid_reg;
    logic [7:0]  table_id_reg, byte3_reg, byte4_a_reg, byte4_b_reg;
    logic        report_all_reg;

    // Packet state
    logic             in_packet_reg, in_packet_next;
    logic [POS_W-1:0] byte_pos_reg, byte_pos_next;
    logic [31:0]      packet_count_reg, packet_count_next;
    logic [12:0]      pid_reg, pid_next;
    logic [6:0]       header_reg, header_next;
    logic [3:0]       cc_reg, cc_next;
    logic [7:0]       adapt_len_reg, adapt_len_next;
    logic [7:0]       adapt_flag_reg, adapt_flag_next;
    logic [32:0]      pcr_base_reg, pcr_base_next;
    logic [8:0]       pcr_ext_reg, pcr_ext_next;
    logic [CNT_W-1:0] capture_count_reg, capture_count_next;
    logic [7:0]       capture_store_reg [CAPTURE_BYTES];

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic        kind_reg;
    logic [31:0] packet_index_reg;
    logic [12:0] packet_pid_reg;
    logic [6:0]  header_bits_reg;
    logic [3:0]  continuity_reg;
    logic [7:0]  adapt_flags_reg;
    logic [32:0] pcr_base_out_reg;
    logic [8:0]  pcr_ext_out_reg;
    logic [12:0] section_length_reg;
    logic [7:0]  data_byte_reg;
    logic [3:0]  byte_index_reg;
    logic        last_reg;

    logic             adapt, unit_start, has_pcr;
    logic [POS_W-1:0] pos_p1;
    logic [OFF_W-1:0] cap_start, cap_off;
    logic             cap_hit;
    logic             matched;
    logic [12:0]      sec_len;

    assign pos_p1     = byte_pos_reg + POS_W'(1);
    assign adapt      = header_reg[1];
    assign unit_start = header_reg[5];
    assign has_pcr    = (adapt_len_reg != 8'd0) && adapt_flag_reg[4];

    assign cap_start = adapt ? (OFF_W'(6) + OFF_W'(adapt_len_reg)) : OFF_W'(5);
    assign cap_off   = OFF_W'(pos_p1) - cap_start;
    assign cap_hit   = in_packet_reg && unit_start && (pos_p1 >= POS_W'(4))
                     && (OFF_W'(pos_p1) >= cap_start)
                     && (cap_off < OFF_W'(CAPTURE_BYTES));

    assign matched = unit_start
                   && (capture_count_reg == CNT_W'(CAPTURE_BYTES))
                   && (pid_reg == filter_pid_reg)
                   && (capture_store_reg[0] == table_id_reg)
                   && (capture_store_reg[3] == byte3_reg)
                   && ((capture_store_reg[4] == byte4_a_reg)
                       || (capture_store_reg[4] == byte4_b_reg));

    assign sec_len = 13'({capture_store_reg[1][3:0], capture_store_reg[2]}) + 13'd3;

    always_comb
    begin
        sts.pkt_end    = in_packet_reg && (byte_pos_reg == POS_W'(PACKET_BYTES - 2));
        sts.matched    = matched;
        sts.report_all = report_all_reg;
        sts.out_free   = !out_valid_reg || out_ready;
    end

    // Byte decode
    always_comb
    begin
        in_packet_next     = in_packet_reg;
        byte_pos_next      = byte_pos_reg;
        packet_count_next  = packet_count_reg;
        pid_next           = pid_reg;
        header_next        = header_reg;
        cc_next            = cc_reg;
        adapt_len_next     = adapt_len_reg;
        adapt_flag_next    = adapt_flag_reg;
        pcr_base_next      = pcr_base_reg;
        pcr_ext_next       = pcr_ext_reg;
        capture_count_next = capture_count_reg;
        if (cmd.accept)
        begin
            if (!in_packet_reg)
            begin
                if (in_byte == SYNC_BYTE)
                begin
                    in_packet_next     = 1'b1;
                    byte_pos_next      = '0;
                    packet_count_next  = packet_count_reg + 32'd1;
                    pid_next           = '0;
                    header_next        = '0;
                    cc_next            = '0;
                    adapt_len_next     = '0;
                    adapt_flag_next    = '0;
                    pcr_base_next      = '0;
                    pcr_ext_next       = '0;
                    capture_count_next = '0;
                end
            end
            else
            begin
                byte_pos_next = pos_p1;
                if (pos_p1 == POS_W'(1))
                begin
                    pid_next    = {in_byte[4:0], 8'h00};
                    header_next = {in_byte[7:5], 4'h0};
                end
                else if (pos_p1 == POS_W'(2))
                begin
                    pid_next = {pid_reg[12:8], in_byte};
                end
                else if (pos_p1 == POS_W'(3))
                begin
                    header_next = {header_reg[6:4], in_byte[7:4]};
                    cc_next     = in_byte[3:0];
                end

                // Adaptation field, header complete by now
                if (adapt)
                begin
                    if (pos_p1 == POS_W'(4))
                    begin
                        adapt_len_next = in_byte;
                    end
                    else if (pos_p1 == POS_W'(5) && adapt_len_reg != 8'd0)
                    begin
                        adapt_flag_next = in_byte;
                    end
                    if (has_pcr)
                    begin
                        if (pos_p1 >= POS_W'(6) && pos_p1 <= POS_W'(9))
                        begin
                            pcr_base_next = {pcr_base_reg[24:0], in_byte};
                        end
                        else if (pos_p1 == POS_W'(10))
                        begin
                            pcr_base_next = {pcr_base_reg[31:0], in_byte[7]};
                            pcr_ext_next  = {in_byte[0], 8'h00};
                        end
                        else if (pos_p1 == POS_W'(11))
                        begin
                            pcr_ext_next = pcr_ext_reg | {1'b0, in_byte};
                        end
                    end
                end

                if (cap_hit)
                begin
                    capture_count_next = capture_count_reg + CNT_W'(1);
                end

                if (pos_p1 == POS_W'(PACKET_BYTES - 1))
                begin
                    in_packet_next = 1'b0;
                    byte_pos_next  = '0;
                end
            end
        end
    end

    assign out_valid_next = (cmd.load_sum || cmd.load_data) ? 1'b1
                          : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_pid_reg    <= RST_FILTER_PID;
            table_id_reg      <= RST_TABLE_ID;
            byte3_reg         <= RST_BYTE3;
            byte4_a_reg       <= RST_BYTE4_A;
            byte4_b_reg       <= RST_BYTE4_B;
            report_all_reg    <= 1'b0;
            in_packet_reg     <= 1'b0;
            byte_pos_reg      <= '0;
            packet_count_reg  <= '0;
            pid_reg           <= '0;
            header_reg        <= '0;
            cc_reg            <= '0;
            adapt_len_reg     <= '0;
            adapt_flag_reg    <= '0;
            pcr_base_reg      <= '0;
            pcr_ext_reg       <= '0;
            capture_count_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_FILTER_PID:    filter_pid_reg <= cfg_data;
                    CFG_TABLE_ID:      table_id_reg   <= cfg_data[7:0];
                    CFG_BYTE3_MATCH:   byte3_reg      <= cfg_data[7:0];
                    CFG_BYTE4_MATCH_A: byte4_a_reg    <= cfg_data[7:0];
                    CFG_BYTE4_MATCH_B: byte4_b_reg    <= cfg_data[7:0];
                    CFG_REPORT_ALL:    report_all_reg <= cfg_data[0];
                    default:           ;
                endcase
            end
            in_packet_reg     <= in_packet_next;
            byte_pos_reg      <= byte_pos_next;
            packet_count_reg  <= packet_count_next;
            pid_reg           <= pid_next;
            header_reg        <= header_next;
            cc_reg            <= cc_next;
            adapt_len_reg     <= adapt_len_next;
            adapt_flag_reg    <= adapt_flag_next;
            pcr_base_reg      <= pcr_base_next;
            pcr_ext_reg       <= pcr_ext_next;
            capture_count_reg <= capture_count_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Capture store and result payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.accept && cap_hit)
        begin
            capture_store_reg[cap_off[CAP_AW-1:0]] <= in_byte;
        end
        if (cmd.load_sum || cmd.load_data)
        begin
            kind_reg         <= cmd.load_data;
            packet_index_reg <= packet_count_reg;
            packet_pid_reg   <= pid_reg;
            header_bits_reg  <= header_reg;
            continuity_reg   <= cc_reg;
            adapt_flags_reg  <= adapt_flag_reg;
            pcr_base_out_reg <= pcr_base_reg;
            pcr_ext_out_reg  <= pcr_ext_reg;
            last_reg         <= cmd.last;
            if (cmd.load_data)
            begin
                section_length_reg <= sec_len;
                data_byte_reg      <= capture_store_reg[cmd.idx[CAP_AW-1:0]];
                byte_index_reg     <= cmd.idx;
            end
            else
            begin
                section_length_reg <= '0;
                data_byte_reg      <= '0;
                byte_index_reg     <= '0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign packet_index   = packet_index_reg;
    assign packet_pid     = packet_pid_reg;
    assign header_bits    = header_bits_reg;
    assign continuity     = continuity_reg;
    assign adapt_flags    = adapt_flags_reg;
    assign pcr_base       = pcr_base_out_reg;
    assign pcr_extension  = pcr_ext_out_reg;
    assign section_length = section_length_reg;
    assign data_byte      = data_byte_reg;
    assign byte_index     = byte_index_reg;
    assign last           = last_reg;

`ifndef SYNTH
    a_cap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        capture_count_reg <= CNT_W'(CAPTURE_BYTES))
        else $error("capture count ran past the window");

    a_data_matched: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_data |-> matched)
        else $error("section beat loaded without a filter match");
`endif

endmodule

// ===== hdl/ts_packet_parser_section_filter_unit.sv =====
// Throughput: one stream byte a cycle while inside or searching for a packet.
// At the last byte of a packet intake pauses for the filter decision, then
// one result beat a cycle while the output register is free (up to 1 + CAPTURE_BYTES).
// The first result of a packet is loaded into the output register after the decision state.
// Reset: asynchronous, active low; clears parser state and loads default filter settings.
// ----------------------------------------------------------------------------
// Transport stream packet parser with section filter
// Hunts for the sync byte, tracks each packet, decodes header, adaptation field
// and PCR, captures the first section bytes after the pointer byte and emits a
// packet summary when report-all is set and the captured run when the filter matches.
// ----------------------------------------------------------------------------
module ts_packet_parser_section_filter_unit
    import tspf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Stream input
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_byte,
    // Configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Result output
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  kind,
    output logic [31:0]           packet_index,
    output logic [12:0]           packet_pid,
    output logic [6:0]            header_bits,
    output logic [3:0]            continuity,
    output logic [7:0]            adapt_flags,
    output logic [32:0]           pcr_base,
    output logic [8:0]            pcr_extension,
    output logic [12:0]           section_length,
    output logic [7:0]            data_byte,
    output logic [3:0]            byte_index,
    output logic                  last
);

    // Commands flow from the controller, status flows back from the datapath.
    cmd_t    cmd;
    status_t sts;

    // Controller: takes a beat per cycle in the run state, holds off intake
    // while the summary and section beats of a finished packet drain.
    tspf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: decode registers, capture store, filter compare and the
    // output register, which lets intake resume while the last beat waits.
    tspf_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_byte        (in_byte),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .sts            (sts),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .kind           (kind),
        .packet_index   (packet_index),
        .packet_pid     (packet_pid),
        .header_bits    (header_bits),
        .continuity     (continuity),
        .adapt_flags    (adapt_flags),
        .pcr_base       (pcr_base),
        .pcr_extension  (pcr_extension),
        .section_length (section_length),
        .data_byte      (data_byte),
        .byte_index     (byte_index),
        .last           (last)
    );

endmodule

// ===== tb/ts_packet_parser_section_filter_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the transport stream packet parser with section filter
// Feeds byte streams of whole packets, noise and lost-sync bursts through the
// input channel, mirrors the parser and the section filter in a behavioural
// predictor, and checks every result beat field by field against the oldest
// predicted beat. Filter registers are rewritten between idle phases.
// ----------------------------------------------------------------------------
module ts_packet_parser_section_filter_unit_tb;
    import tspf_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 5;
    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int HOLD_OFF_CYCLES = 900;

    // Adaptation field control codes in the packet header
    localparam logic [1:0] AFC_RESERVED      = 2'b00;
    localparam logic [1:0] AFC_PAYLOAD_ONLY  = 2'b01;
    localparam logic [1:0] AFC_ADAPT_ONLY    = 2'b10;
    localparam logic [1:0] AFC_ADAPT_PAYLOAD = 2'b11;

    // Register indexes that decode to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    // Bit of the adaptation flags byte that announces a PCR
    localparam int PCR_FLAG_BIT = 4;

    // How a section head is built
    localparam int SEC_RANDOM = 0;
    localparam int SEC_MATCH  = 1;
    localparam int SEC_BROKEN = 2;

    // One result beat as the block should present it
    typedef struct packed {
        logic        kind;
        logic [31:0] index;
        logic [12:0] pid;
        logic [6:0]  hdr;
        logic [3:0]  cc;
        logic [7:0]  aflags;
        logic [32:0] pcr_base;
        logic [8:0]  pcr_ext;
        logic [12:0] sec_len;
        logic [7:0]  data;
        logic [3:0]  idx;
        logic        last;
    } beat_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block pins
    // ------------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [7:0]            in_byte   = 8'h00;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  kind;
    logic [31:0]           packet_index;
    logic [12:0]           packet_pid;
    logic [6:0]            header_bits;
    logic [3:0]            continuity;
    logic [7:0]            adapt_flags;
    logic [32:0]           pcr_base;
    logic [8:0]            pcr_extension;
    logic [12:0]           section_length;
    logic [7:0]            data_byte;
    logic [3:0]            byte_index;
    logic                  last;

    always #HALF_PERIOD clk = ~clk;

    ts_packet_parser_section_filter_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .packet_index   (packet_index),
        .packet_pid     (packet_pid),
        .header_bits    (header_bits),
        .continuity     (continuity),
        .adapt_flags    (adapt_flags),
        .pcr_base       (pcr_base),
        .pcr_extension  (pcr_extension),
        .section_length (section_length),
        .data_byte      (data_byte),
        .byte_index     (byte_index),
        .last           (last)
    );

    // ------------------------------------------------------------------------
    // Filter register mirror, loaded with the reset defaults
    // ------------------------------------------------------------------------
    logic [12:0] m_filter_pid = RST_FILTER_PID;
    logic [7:0]  m_table_id   = RST_TABLE_ID;
    logic [7:0]  m_byte3      = RST_BYTE3;
    logic [7:0]  m_byte4_a    = RST_BYTE4_A;
    logic [7:0]  m_byte4_b    = RST_BYTE4_B;
    logic        m_report_all = 1'b0;

    // ------------------------------------------------------------------------
    // Parser mirror
    // ------------------------------------------------------------------------
    logic        pr_in_packet = 1'b0;
    logic [7:0]  pr_pos       = '0;
    logic [31:0] pr_count     = '0;
    logic [12:0] pr_pid       = '0;
    logic [6:0]  pr_hdr       = '0;
    logic [3:0]  pr_cc        = '0;
    logic [7:0]  pr_alen      = '0;
    logic [7:0]  pr_aflags    = '0;
    logic [32:0] pr_pcr_base  = '0;
    logic [8:0]  pr_pcr_ext   = '0;
    logic [7:0]  pr_window [CAPTURE_BYTES];
    int          pr_captured  = 0;

    beat_t expected_beats [$];

    // Stimulus buffers and run bookkeeping
    logic [7:0] pkt     [PACKET_BYTES];
    logic [7:0] sec_buf [CAPTURE_BYTES];

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int hold_request    = 0;
    int hold_left       = 0;
    int error_count     = 0;
    int beats_checked   = 0;
    int beats_predicted = 0;
    int sections_hit    = 0;
    int intake_stalls   = 0;
    int cycle_count     = 0;

    // ------------------------------------------------------------------------
    // Predictor: advance the parser mirror by one accepted stream byte and
    // queue whatever beats the end of a packet produces
    // ------------------------------------------------------------------------
    task automatic parse_byte(input logic [7:0] b);
        int          p;
        int          start;
        logic        adapt;
        logic        unit_start;
        logic        matched;
        logic [12:0] sec_len;
        beat_t       r;
        if (!pr_in_packet) begin
            // Hunt: drop everything but the sync byte
            if (b == SYNC_BYTE) begin
                pr_in_packet = 1'b1;
                pr_pos       = '0;
                pr_count     = pr_count + 1;
                pr_pid       = '0;
                pr_hdr       = '0;
                pr_cc        = '0;
                pr_alen      = '0;
                pr_aflags    = '0;
                pr_pcr_base  = '0;
                pr_pcr_ext   = '0;
                pr_captured  = 0;
            end
            return;
        end

        p      = int'(pr_pos) + 1;
        pr_pos = p[7:0];

        case (p)
            1: begin
                pr_pid = {b[4:0], 8'h00};
                pr_hdr = {b[7:5], 4'h0};
            end
            2: pr_pid[7:0] = b;
            3: begin
                pr_hdr[3:0] = b[7:4];
                pr_cc       = b[3:0];
            end
            default: ;
        endcase

        adapt      = pr_hdr[1];
        unit_start = pr_hdr[5];

        if (adapt) begin
            if (p == 4)
                pr_alen = b;
            else if (p == 5 && pr_alen != 0)
                pr_aflags = b;
            // PCR bytes are taken whenever the flag is set, even in a short field
            if (pr_alen != 0 && pr_aflags[PCR_FLAG_BIT]) begin
                if (p >= 6 && p <= 9) begin
                    pr_pcr_base = {pr_pcr_base[24:0], b};
                end else if (p == 10) begin
                    pr_pcr_base = {pr_pcr_base[31:0], b[7]};
                    pr_pcr_ext  = {b[0], 8'h00};
                end else if (p == 11) begin
                    pr_pcr_ext[7:0] = b;
                end
            end
        end

        // Capture window starts one byte after the pointer byte
        if (unit_start && p >= 4) begin
            start = adapt ? 6 + int'(pr_alen) : 5;
            if (p >= start && p < start + CAPTURE_BYTES) begin
                pr_window[p - start] = b;
                pr_captured++;
            end
        end

        if (p + 1 < PACKET_BYTES)
            return;

        pr_in_packet = 1'b0;
        pr_pos       = '0;

        matched = unit_start && pr_captured == CAPTURE_BYTES &&
                  pr_pid == m_filter_pid &&
                  pr_window[0] == m_table_id &&
                  pr_window[3] == m_byte3 &&
                  (pr_window[4] == m_byte4_a || pr_window[4] == m_byte4_b);

        r.kind     = 1'b0;
        r.index    = pr_count;
        r.pid      = pr_pid;
        r.hdr      = pr_hdr;
        r.cc       = pr_cc;
        r.aflags   = pr_aflags;
        r.pcr_base = pr_pcr_base;
        r.pcr_ext  = pr_pcr_ext;
        r.sec_len  = '0;
        r.data     = '0;
        r.idx      = '0;
        r.last     = !matched;
        if (m_report_all) begin
            expected_beats.push_back(r);
            beats_predicted++;
        end

        if (matched) begin
            sections_hit++;
            sec_len = {1'b0, pr_window[1][3:0], pr_window[2]} + 13'd3;
            for (int i = 0; i < CAPTURE_BYTES; i++) begin
                r.kind    = 1'b1;
                r.sec_len = sec_len;
                r.data    = pr_window[i];
                r.idx     = i[3:0];
                r.last    = (i == CAPTURE_BYTES - 1);
                expected_beats.push_back(r);
                beats_predicted++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offer one byte; return at the falling edge after it is accepted
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        parse_byte(b);
        @(negedge clk);
    endtask

    task automatic send_packet();
        for (int i = 0; i < PACKET_BYTES; i++)
            send_byte(pkt[i]);
    endtask

    // Pad out a packet left open by noise so the next sync lands on byte 0
    task automatic realign();
        while (pr_in_packet)
            send_byte(8'h00);
    endtask

    // Close any open packet, drop valid and hold until every beat is back
    task automatic settle();
        realign();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_wr_en <= 1'b1;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_FILTER_PID:    m_filter_pid = data[12:0];
            CFG_TABLE_ID:      m_table_id   = data[7:0];
            CFG_BYTE3_MATCH:   m_byte3      = data[7:0];
            CFG_BYTE4_MATCH_A: m_byte4_a    = data[7:0];
            CFG_BYTE4_MATCH_B: m_byte4_b    = data[7:0];
            CFG_REPORT_ALL:    m_report_all = data[0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic configure_filter(input logic [12:0] pid, input logic [7:0] tid,
                                    input logic [7:0] b3, input logic [7:0] b4a,
                                    input logic [7:0] b4b, input logic rep);
        write_reg(CFG_FILTER_PID, pid);
        write_reg(CFG_TABLE_ID, CFG_DATA_W'(tid));
        write_reg(CFG_BYTE3_MATCH, CFG_DATA_W'(b3));
        write_reg(CFG_BYTE4_MATCH_A, CFG_DATA_W'(b4a));
        write_reg(CFG_BYTE4_MATCH_B, CFG_DATA_W'(b4b));
        write_reg(CFG_REPORT_ALL, CFG_DATA_W'(rep));
    endtask

    function automatic logic [6:0] hdr_bits(input logic tei, input logic pusi,
                                            input logic prio, input logic [1:0] scr,
                                            input logic [1:0] afc);
        return {tei, pusi, prio, scr, afc};
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == SYNC_BYTE)
            b = ~SYNC_BYTE;
        return b;
    endfunction

    // Fill the section head: random, matching the mirror, or one field spoilt
    task automatic make_section(input int mode);
        for (int i = 0; i < CAPTURE_BYTES; i++)
            sec_buf[i] = 8'($urandom);
        if (mode != SEC_RANDOM) begin
            sec_buf[0] = m_table_id;
            sec_buf[3] = m_byte3;
            sec_buf[4] = $urandom_range(0, 1) ? m_byte4_a : m_byte4_b;
        end
        if (mode == SEC_BROKEN) begin
            case ($urandom_range(0, 2))
                0:       sec_buf[0] = sec_buf[0] ^ (8'h01 << $urandom_range(0, 7));
                1:       sec_buf[3] = sec_buf[3] ^ (8'h01 << $urandom_range(0, 7));
                default: sec_buf[4] = sec_buf[4] ^ (8'h01 << $urandom_range(0, 7));
            endcase
        end
    endtask

    // Build a whole packet in pkt: header, adaptation field, PCR, then the
    // section head from sec_buf behind the pointer byte; the rest is random
    task automatic form_packet(input logic [12:0] pid, input logic [6:0] hdr,
                               input logic [3:0] cc, input logic [7:0] alen,
                               input logic [7:0] aflags, input logic [32:0] pbase,
                               input logic [8:0] pext);
        logic [5:0] rsv;
        int         start;
        rsv = 6'($urandom);
        for (int i = 0; i < PACKET_BYTES; i++)
            pkt[i] = 8'($urandom);
        pkt[0] = SYNC_BYTE;
        pkt[1] = {hdr[6:4], pid[12:8]};
        pkt[2] = pid[7:0];
        pkt[3] = {hdr[3:0], cc};
        if (hdr[1]) begin
            pkt[4] = alen;
            if (alen != 0) begin
                pkt[5] = aflags;
                if (aflags[PCR_FLAG_BIT]) begin
                    pkt[6]  = pbase[32:25];
                    pkt[7]  = pbase[24:17];
                    pkt[8]  = pbase[16:9];
                    pkt[9]  = pbase[8:1];
                    pkt[10] = {pbase[0], rsv, pext[8]};
                    pkt[11] = pext[7:0];
                end
            end
        end
        start = hdr[1] ? 6 + int'(alen) : 5;
        for (int i = 0; i < CAPTURE_BYTES; i++)
            if (start + i < PACKET_BYTES)
                pkt[start + i] = sec_buf[i];
    endtask

    // Mostly well-formed packets with random content; some noise, spoilt
    // sections, foreign PIDs and the odd packet whose sync byte is lost
    task automatic random_packet();
        logic [12:0] pid;
        logic [7:0]  alen;
        logic [7:0]  aflags;
        logic [32:0] pbase;
        logic [8:0]  pext;
        logic [3:0]  cc;
        logic [6:0]  hdr;
        logic        lost_sync;
        int          roll;
        if ($urandom_range(0, 99) < 12)
            repeat ($urandom_range(1, 6)) send_byte(noise_byte());

        pid = 13'($urandom);
        if ($urandom_range(0, 99) < 65)
            pid = m_filter_pid;
        hdr = hdr_bits($urandom_range(0, 99) < 10, $urandom_range(0, 99) < 85,
                       1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                       2'($urandom_range(0, 3)));
        cc  = 4'($urandom);

        roll = $urandom_range(0, 9);
        if (roll <= 5)
            alen = 8'($urandom_range(0, 12));
        else if (roll == 6)
            alen = 8'd0;
        else if (roll == 7)
            alen = 8'($urandom_range(166, 170));
        else if (roll == 8)
            alen = 8'($urandom_range(171, 255));
        else
            alen = 8'($urandom_range(13, 160));

        aflags               = 8'($urandom);
        aflags[PCR_FLAG_BIT] = ($urandom_range(0, 99) < 60);
        pbase[31:0]          = $urandom;
        pbase[32]            = 1'($urandom_range(0, 1));
        pext                 = 9'($urandom);

        roll = $urandom_range(0, 99);
        make_section(roll < 70 ? SEC_MATCH : (roll < 90 ? SEC_BROKEN : SEC_RANDOM));
        form_packet(pid, hdr, cc, alen, aflags, pbase, pext);

        lost_sync = ($urandom_range(0, 99) < 5);
        if (lost_sync)
            pkt[0] = noise_byte();
        send_packet();
        if (lost_sync)
            realign();
    endtask

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------

    // Drive ready; a requested hold-off takes precedence over random stalls
    always @(negedge clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left--;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: result beat %0d, %s: got 0x%0h, expected 0x%0h",
                 $time, beats_checked, field, got, want);
        error_count++;
    endtask

    // Compare each accepted beat with the oldest prediction
    always @(posedge clk) begin : result_check
        beat_t want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_beats.size() == 0) begin
                report_mismatch("beat with nothing expected, pid", 64'(packet_pid), '0);
            end else begin
                want = expected_beats.pop_front();
                if (kind !== want.kind)
                    report_mismatch("kind", 64'(kind), 64'(want.kind));
                if (packet_index !== want.index)
                    report_mismatch("packet_index", 64'(packet_index), 64'(want.index));
                if (packet_pid !== want.pid)
                    report_mismatch("packet_pid", 64'(packet_pid), 64'(want.pid));
                if (header_bits !== want.hdr)
                    report_mismatch("header_bits", 64'(header_bits), 64'(want.hdr));
                if (continuity !== want.cc)
                    report_mismatch("continuity", 64'(continuity), 64'(want.cc));
                if (adapt_flags !== want.aflags)
                    report_mismatch("adapt_flags", 64'(adapt_flags), 64'(want.aflags));
                if (pcr_base !== want.pcr_base)
                    report_mismatch("pcr_base", 64'(pcr_base), 64'(want.pcr_base));
                if (pcr_extension !== want.pcr_ext)
                    report_mismatch("pcr_extension", 64'(pcr_extension),
                                    64'(want.pcr_ext));
                if (section_length !== want.sec_len)
                    report_mismatch("section_length", 64'(section_length),
                                    64'(want.sec_len));
                if (data_byte !== want.data)
                    report_mismatch("data_byte", 64'(data_byte), 64'(want.data));
                if (byte_index !== want.idx)
                    report_mismatch("byte_index", 64'(byte_index), 64'(want.idx));
                if (last !== want.last)
                    report_mismatch("last", 64'(last), 64'(want.last));
            end
            beats_checked++;
        end
    end

    // Watchdog, plus a count of cycles the block refused an offered byte
    always @(posedge clk) begin
        cycle_count++;
        if (rst_n && in_valid && !in_ready)
            intake_stalls++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles with %0d beats outstanding",
                     cycle_count, expected_beats.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hunt through noise for the sync byte; a sync value inside a packet is
    // just payload. Both accepted values of section byte 4 match.
    task automatic test_sync_hunt();
        logic [7:0] junk [6] = '{8'h00, 8'hff, 8'h46, 8'h48, 8'hc7, 8'hb8};
        foreach (junk[i])
            send_byte(junk[i]);
        make_section(SEC_MATCH);
        sec_buf[4] = m_byte4_a;
        form_packet(m_filter_pid, hdr_bits(1'b0, 1'b1, 1'b0, 2'b00, AFC_PAYLOAD_ONLY),
                    4'h0, 8'h00, 8'h00, '0, '0);
        pkt[60]               = SYNC_BYTE;
        pkt[PACKET_BYTES - 1] = SYNC_BYTE;
        send_packet();
        make_section(SEC_MATCH);
        sec_buf[4] = m_byte4_b;
        form_packet(m_filter_pid, hdr_bits(1'b0, 1'b1, 1'b1, 2'b10, AFC_PAYLOAD_ONLY),
                    4'hf, 8'h00, 8'h00, '0, '0);
        send_packet();
        settle();
    endtask

    // Spare indexes change nothing; upper data bits are dropped; run the
    // filter at both ends of every register
    task automatic test_register_writes();
        write_reg(CFG_SPARE_6, '1);
        write_reg(CFG_SPARE_7, '1);
        make_section(SEC_MATCH);
        form_packet(m_filter_pid, hdr_bits(1'b0, 1'b1, 1'b0, 2'b01, AFC_PAYLOAD_ONLY),
                    4'h5, 8'h00, 8'h00, '0, '0);
        send_packet();
        settle();

        write_reg(CFG_FILTER_PID, 13'h1fff);
        write_reg(CFG_TABLE_ID, 13'h1fff);
        write_reg(CFG_BYTE3_MATCH, 13'h1fff);
        write_reg(CFG_BYTE4_MATCH_A, 13'h1fff);
        write_reg(CFG_BYTE4_MATCH_B, 13'h1f00);
        write_reg(CFG_REPORT_ALL, 13'h1fff);

        // Every header bit set, zero-length adaptation field, longest section
        make_section(SEC_MATCH);
        sec_buf[1] = 8'hff;
        sec_buf[2] = 8'hff;
        form_packet(13'h1fff, 7'h7f, 4'hf, 8'h00, 8'h00, '0, '0);
        send_packet();
        // Foreign PID, then unit start clear: summaries only
        make_section(SEC_MATCH);
        form_packet(13'h0000, hdr_bits(1'b0, 1'b1, 1'b0, 2'b00, AFC_PAYLOAD_ONLY),
                    4'h0, 8'h00, 8'h00, '0, '0);
        send_packet();
        make_section(SEC_MATCH);
        form_packet(13'h1fff, hdr_bits(1'b1, 1'b0, 1'b0, 2'b11, AFC_PAYLOAD_ONLY),
                    4'h9, 8'h00, 8'h00, '0, '0);
        send_packet();
        settle();

        // Match registers at zero, report-all set; reserved adaptation control means no field
        configure_filter(13'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
        make_section(SEC_MATCH);
        sec_buf[1] = 8'h00;
        sec_buf[2] = 8'h00;
        form_packet(13'h0000, hdr_bits(1'b0, 1'b1, 1'b0, 2'b00, AFC_RESERVED),
                    4'h0, 8'h00, 8'h00, '0, '0);
        send_packet();
        settle();
    endtask

    // Adaptation length, flags and PCR decoding, including the awkward cases
    task automatic test_adaptation_field();
        logic [32:0] pbase;
        configure_filter(RST_FILTER_PID, RST_TABLE_ID, RST_BYTE3, RST_BYTE4_A,
                         RST_BYTE4_B, 1'b1);
        pbase[31:0] = $urandom;
        pbase[32]   = 1'b1;

        // Largest PCR with every flag set
        make_section(SEC_MATCH);
        form_packet(m_filter_pid, hdr_bits(1'b0, 1'b1, 1'b0, 2'b00, AFC_ADAPT_PAYLOAD),
                    4'h3, 8'd7, 8'hff, 33'h1_ffff_ffff, 9'h1ff);
        send_packet();
        make_section(SEC_MATCH);
        form_packet(m_filter_pid, hdr_bits(1'b0, 1'b1, 1'b0, 2'b01, AFC_ADAPT_PAYLOAD),
                    4'h4, 8'd7, 8'h10, pbase, 9'h0a5);
        send_packet();
        // Zero adaptation length: the byte after it must not be taken as flags
        make_section(SEC_MATCH);
        form_packet(m_filter_pid, hdr_bits(1'b0, 1'b1, 1'b0, 2'b00, AFC_ADAPT_PAYLOAD),
                    4'h5, 8'd0, 8'h00, '0, '0);
        pkt[5] = 8'hff;
        send_packet();
        // PCR flag in a one-byte field: PCR bytes still come from bytes 6 to 11
        make_section(SEC_MATCH);
        form_packet(m_filter_pid, hdr_bits(1'b0, 1'b1, 1'b0, 2'b00, AFC_ADAPT_PAYLOAD),
                    4'h6, 8'd1, 8'h10, pbase, 9'h155);
        send_packet();
        // Adaptation only, unit start set: capture runs where payload would be
        make_section(SEC_MATCH);
        form_packet(m_filter_pid, hdr_bits(1'b0, 1'b1, 1'b0, 2'b00, AFC_ADAPT_ONLY),
                    4'h7, 8'd20, 8'h10, 33'h0_0000_0001, 9'h001);
        send_packet();
        // Flags without PCR
        make_section(SEC_MATCH);
        form_packet(m_filter_pid, hdr_bits(1'b0, 1'b1, 1'b0, 2'b00, AFC_ADAPT_PAYLOAD),
                    4'h8, 8'd3, 8'hef, '0, '0);
        send_packet();
        settle();
    endtask

    // Capture window that just fits, and ones that run past the packet end
    task automatic test_capture_window_edges();
        logic [7:0] lens [5] = '{8'd168, 8'd169, 8'd182, 8'd255, 8'd167};
        foreach (lens[i]) begin
            make_section(SEC_MATCH);
            form_packet(m_filter_pid,
                        hdr_bits(1'b0, 1'b1, 1'b0, 2'b00,
                                 (i == 4) ? AFC_ADAPT_ONLY : AFC_ADAPT_PAYLOAD),
                        i[3:0], lens[i], 8'h00, '0, '0);
            send_packet();
        end
        settle();
    endtask

    // Random traffic with the given idle mix, run until enough beats are due
    task automatic test_random_traffic(input int packets, input int s_idle,
                                       input int r_idle);
        int due_at_start;
        int n;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        due_at_start  = beats_predicted;
        n             = 0;
        while ((n < packets || beats_predicted - due_at_start < 48) && n < 4 * packets) begin
            random_packet();
            n++;
        end
        settle();
    endtask

    // Hold the output off for a long stretch while packets keep coming, so
    // the result path backs up into the intake
    task automatic test_input_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = HOLD_OFF_CYCLES;
        repeat (5) begin
            make_section(SEC_MATCH);
            form_packet(m_filter_pid, hdr_bits(1'b0, 1'b1, 1'b0, 2'b00, AFC_PAYLOAD_ONLY),
                        4'($urandom), 8'h00, 8'h00, '0, '0);
            send_packet();
        end
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part under the first idle mix
        send_idle_pct = 37;
        recv_idle_pct = 73;
        test_sync_hunt();
        test_register_writes();
        test_adaptation_field();
        test_capture_window_edges();

        // Random part: three idle mixes, each under a different filter setting
        configure_filter(13'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 1'b1);
        test_random_traffic(14, 37, 73);
        configure_filter(13'h1fff, 8'hff, 8'hff, 8'hff, 8'h00, 1'b0);
        test_random_traffic(14, 73, 37);
        configure_filter(13'h0000, 8'h00, 8'h00, 8'h00, 8'hff, 1'b1);
        test_random_traffic(14, 0, 0);

        configure_filter(RST_FILTER_PID, RST_TABLE_ID, RST_BYTE3, RST_BYTE4_A,
                         RST_BYTE4_B, 1'b1);
        test_input_backpressure();

        $display("run covered %0d packets, %0d matched sections, %0d result beats checked",
                 pr_count, sections_hit, beats_checked);
        $display("idle mixes 37/73, 73/37 and none; intake refused bytes for %0d cycles",
                 intake_stalls);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
